@@ rtl/vng_pkg.sv @@
// Package: shared constants, types and helpers of the vertex normal generator.
`default_nettype none
package vng_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_SUM_WIDTH    = 40;
    localparam int IDX_W            = 10;
    localparam int NRM_W            = 16;
    localparam int EDGE_W           = 17;
    localparam int FACE_W           = 35;
    localparam int MAG_W            = 30;
    localparam int SQ_W             = 60;
    localparam int LEN_W            = 32;
    localparam int QUO_W            = 16;
    localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_TRI   = 2'd2,
        REQ_READ  = 2'd3
    } vng_req_e;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } vng_vec_t;

    typedef struct packed {
        logic load;
        logic shr;
        logic shl;
        logic div_init;
        logic div_step;
    } vng_lane_ctl_t;

    typedef struct packed {
        logic sqrt_init;
        logic sqrt_step;
    } vng_merge_ctl_t;

    typedef struct packed {
        logic all_zero;
        logic any_big;
        logic all_small;
        logic sqrt_done;
    } vng_merge_stat_t;

    // squared length below 3 LSB squared
    function automatic logic vng_short(input vng_vec_t v);
        logic ux;
        logic uy;
        logic uz;
        ux = (v.x == 16'sd0) || (v.x == 16'sd1) || (v.x == -16'sd1);
        uy = (v.y == 16'sd0) || (v.y == 16'sd1) || (v.y == -16'sd1);
        uz = (v.z == 16'sd0) || (v.z == 16'sd1) || (v.z == -16'sd1);
        return ux && uy && uz && !((v.x != 16'sd0) && (v.y != 16'sd0) && (v.z != 16'sd0));
    endfunction

endpackage
`default_nettype wire

@@ rtl/vng_if.sv @@
// Interfaces: request and response channels of the vertex normal generator.
`default_nettype none
interface vng_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] in_normal_x;
    logic signed [15:0] in_normal_y;
    logic signed [15:0] in_normal_z;
    logic               normal_finite;
    logic [9:0]         corner_a;
    logic [9:0]         corner_b;
    logic [9:0]         corner_c;

    modport source (
        output valid, req_type, pos_x, pos_y, pos_z, in_normal_x, in_normal_y, in_normal_z,
               normal_finite, corner_a, corner_b, corner_c,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, pos_z, in_normal_x, in_normal_y, in_normal_z,
               normal_finite, corner_a, corner_b, corner_c,
        output ready
    );
endinterface

interface vng_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_normal_x;
    logic signed [15:0] out_normal_y;
    logic signed [15:0] out_normal_z;
    logic [9:0]         vertex_index;
    logic               was_generated;

    modport source (
        output valid, out_normal_x, out_normal_y, out_normal_z, vertex_index, was_generated,
        input  ready
    );
    modport sink (
        input  valid, out_normal_x, out_normal_y, out_normal_z, vertex_index, was_generated,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/vng_lane.sv @@
// Lane: one vector component - cross term, saturating add, scaling and division.
`default_nettype none
module vng_lane
    import vng_pkg::*;
#(
    parameter int SUM_WIDTH = DEF_SUM_WIDTH
)(
    input  wire logic                        clk,
    input  wire vng_lane_ctl_t               ctl,
    input  wire logic signed [EDGE_W-1:0]    mul_a,
    input  wire logic signed [EDGE_W-1:0]    mul_b,
    input  wire logic signed [EDGE_W-1:0]    mul_c,
    input  wire logic signed [EDGE_W-1:0]    mul_d,
    input  wire logic signed [SUM_WIDTH-1:0] sum_in,
    input  wire logic [LEN_W-1:0]            len,
    output logic signed [SUM_WIDTH-1:0]      sum_out,
    output logic                             sum_sat,
    output logic [SUM_WIDTH-1:0]             mag,
    output logic [SQ_W-1:0]                  sq,
    output logic signed [NRM_W-1:0]          comp
);

    localparam logic signed [SUM_WIDTH-1:0] SUM_HI = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_LO = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [2*EDGE_W-1:0] prod1_reg;
    logic signed [2*EDGE_W-1:0] prod2_reg;
    logic signed [FACE_W-1:0]   face_reg;
    logic [SUM_WIDTH-1:0]       mag_reg;
    logic                       neg_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [LEN_W:0]             rem_reg;
    logic [QUO_W-1:0]           numlo_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic signed [SUM_WIDTH:0]  wide;
    logic [SUM_WIDTH-1:0]       mag_next;
    logic [44:0]                num;
    logic [LEN_W+1:0]           trial;
    logic                       ge;

    assign wide     = (SUM_WIDTH+1)'(sum_in) + (SUM_WIDTH+1)'(face_reg);
    assign sum_sat  = wide[SUM_WIDTH] != wide[SUM_WIDTH-1];
    assign sum_out  = sum_sat ? (wide[SUM_WIDTH] ? SUM_LO : SUM_HI) : wide[SUM_WIDTH-1:0];
    assign mag_next = sum_in[SUM_WIDTH-1] ? (~sum_in + 1'b1) : sum_in;
    assign num      = 45'({mag_reg[MAG_W-1:0], 14'd0}) + 45'(len[LEN_W-1:1]);
    assign trial    = {rem_reg, numlo_reg[QUO_W-1]};
    assign ge       = trial >= {2'b00, len};

    always_ff @(posedge clk)
    begin
        prod1_reg <= mul_a * mul_b;
        prod2_reg <= mul_c * mul_d;
        face_reg  <= FACE_W'(prod1_reg) - FACE_W'(prod2_reg);
        sq_reg    <= SQ_W'(mag_reg[MAG_W-1:0]) * SQ_W'(mag_reg[MAG_W-1:0]);
        if (ctl.load)
        begin
            mag_reg <= mag_next;
            neg_reg <= sum_in[SUM_WIDTH-1];
        end
        else if (ctl.shr)
        begin
            mag_reg <= mag_reg >> 1;
        end
        else if (ctl.shl)
        begin
            mag_reg <= mag_reg << 1;
        end
        if (ctl.div_init)
        begin
            rem_reg   <= (LEN_W+1)'(num[44:16]);
            numlo_reg <= num[15:0];
            quo_reg   <= '0;
        end
        else if (ctl.div_step)
        begin
            rem_reg   <= ge ? (LEN_W+1)'(trial - {2'b00, len}) : trial[LEN_W:0];
            numlo_reg <= numlo_reg << 1;
            quo_reg   <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign mag  = mag_reg;
    assign sq   = sq_reg;
    assign comp = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule
`default_nettype wire

@@ rtl/vng_merge.sv @@
// Merge: range tests across lanes, sum of squares and bit-pair square root.
`default_nettype none
module vng_merge
    import vng_pkg::*;
#(
    parameter int SUM_WIDTH = DEF_SUM_WIDTH
)(
    input  wire logic                 clk,
    input  wire vng_merge_ctl_t       ctl,
    input  wire logic [SUM_WIDTH-1:0] mag_x,
    input  wire logic [SUM_WIDTH-1:0] mag_y,
    input  wire logic [SUM_WIDTH-1:0] mag_z,
    input  wire logic [SQ_W-1:0]      sq_x,
    input  wire logic [SQ_W-1:0]      sq_y,
    input  wire logic [SQ_W-1:0]      sq_z,
    output vng_merge_stat_t           stat,
    output logic [LEN_W-1:0]          len
);

    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.sqrt_init)
        begin
            v_reg   <= 64'(sq_x) + 64'(sq_y) + 64'(sq_z);
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (ctl.sqrt_step)
        begin
            if (v_reg >= trial)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign stat.all_zero  = (mag_x == '0) && (mag_y == '0) && (mag_z == '0);
    assign stat.any_big   = (|mag_x[SUM_WIDTH-1:MAG_W]) || (|mag_y[SUM_WIDTH-1:MAG_W])
                            || (|mag_z[SUM_WIDTH-1:MAG_W]);
    assign stat.all_small = !((|mag_x[SUM_WIDTH-1:MAG_W-1]) || (|mag_y[SUM_WIDTH-1:MAG_W-1])
                            || (|mag_z[SUM_WIDTH-1:MAG_W-1]));
    assign stat.sqrt_done = bit_reg == '0;
    assign len            = res_reg[LEN_W-1:0];

endmodule
`default_nettype wire

@@ rtl/vertex_normal_generator_top.sv @@
// Top level: sequencer, vertex memories, three component lanes and the merge stage.
//
//  channel  dir  handshake      moves
//  req      in   valid/ready    start, load, triangle or read request
//  rsp      out  valid/ready    final normal of a read request
//
// Start and load requests are taken in S_IDLE; a triangle does three position reads
// and three sum read-modify-writes on memories with one read and one write port.
// A read of a loaded normal passes S_RCHK to S_RFIN; a generated one also runs the
// scaling shift, a 32-step square root and a 16-step division per lane. Reset clears
// the vertex count and the sequencer; the memories are not cleared. A stalled
// response is held in the output register while the next request is taken.
`default_nettype none
module vertex_normal_generator_top
    import vng_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int SUM_WIDTH    = DEF_SUM_WIDTH
)(
    input  wire logic clk,
    input  wire logic rst_n,
    vng_req_if.sink   req,
    vng_rsp_if.source rsp
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int XW   = (AW > IDX_W) ? AW : IDX_W;
    localparam int CMPW = (CNTW > IDX_W) ? CNTW : IDX_W;

    typedef struct packed {
        logic                        missing;
        logic                        sat;
        logic signed [SUM_WIDTH-1:0] sx;
        logic signed [SUM_WIDTH-1:0] sy;
        logic signed [SUM_WIDTH-1:0] sz;
    } sum_word_t;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_TA     = 14'b00000000000010,
        S_TB     = 14'b00000000000100,
        S_TC     = 14'b00000000001000,
        S_TMUL   = 14'b00000000010000,
        S_TSUB   = 14'b00000000100000,
        S_TRD    = 14'b00000001000000,
        S_TUPD   = 14'b00000010000000,
        S_RCHK   = 14'b00000100000000,
        S_RSHIFT = 14'b00001000000000,
        S_RSUM   = 14'b00010000000000,
        S_RSQRT  = 14'b00100000000000,
        S_RDIV   = 14'b01000000000000,
        S_RFIN   = 14'b10000000000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CNTW-1:0]      count_reg;
    logic [IDX_W-1:0]     ca_reg;
    logic [IDX_W-1:0]     cb_reg;
    logic [IDX_W-1:0]     cc_reg;
    logic [1:0]           k_reg;
    logic [3:0]           div_cnt_reg;
    logic                 pend_reg;
    vng_vec_t             pa_reg;
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    vng_vec_t             res_reg;
    logic                 res_gen_reg;
    vng_vec_t             out_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic                 out_gen_reg;
    logic                 out_valid_reg;

    vng_vec_t             pos_mem [MAX_VERTICES];
    vng_vec_t             nrm_mem [MAX_VERTICES];
    sum_word_t            sum_mem [MAX_VERTICES];
    vng_vec_t             pos_rd_reg;
    vng_vec_t             nrm_rd_reg;
    sum_word_t            sum_rd_reg;

    logic                 accept;
    logic                 do_load;
    logic                 a_ok;
    logic                 b_ok;
    logic                 c_ok;
    logic [IDX_W-1:0]     corner_k;
    logic [IDX_W-1:0]     pos_rc;
    logic [IDX_W-1:0]     sum_rc;
    logic [XW-1:0]        pos_rx;
    logic [XW-1:0]        sum_rx;
    logic [XW-1:0]        nrm_rx;
    logic [XW-1:0]        upd_x;
    logic                 sum_we;
    logic [AW-1:0]        sum_wa;
    sum_word_t            sum_wd;
    sum_word_t            sum_upd;
    vng_vec_t             in_pos;
    vng_vec_t             in_nrm;
    vng_vec_t             gen_vec;
    logic                 out_free;

    vng_lane_ctl_t               lane_ctl;
    vng_merge_ctl_t              merge_ctl;
    vng_merge_stat_t             mstat;
    logic [LEN_W-1:0]            len;
    logic signed [SUM_WIDTH-1:0] lane_sum_in  [3];
    logic signed [SUM_WIDTH-1:0] lane_sum_out [3];
    logic                        lane_sat     [3];
    logic [SUM_WIDTH-1:0]        lane_mag     [3];
    logic [SQ_W-1:0]             lane_sq      [3];
    logic signed [NRM_W-1:0]     lane_comp    [3];

    assign accept  = req.valid && req.ready;
    assign do_load = accept && (req.req_type == REQ_LOAD)
                     && (count_reg < CNTW'(MAX_VERTICES));
    assign a_ok    = CMPW'(req.corner_a) < CMPW'(count_reg);
    assign b_ok    = CMPW'(req.corner_b) < CMPW'(count_reg);
    assign c_ok    = CMPW'(req.corner_c) < CMPW'(count_reg);
    assign in_pos  = '{x: req.pos_x, y: req.pos_y, z: req.pos_z};
    assign in_nrm  = '{x: req.in_normal_x, y: req.in_normal_y, z: req.in_normal_z};
    assign gen_vec = '{x: lane_comp[0], y: lane_comp[1], z: lane_comp[2]};
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        case (k_reg)
            2'd0:    corner_k = ca_reg;
            2'd1:    corner_k = cb_reg;
            default: corner_k = cc_reg;
        endcase
    end

    assign pos_rc = (state_reg == S_IDLE) ? req.corner_a
                    : ((state_reg == S_TA) ? cb_reg : cc_reg);
    assign sum_rc = (state_reg == S_IDLE) ? req.corner_a : corner_k;
    assign pos_rx = XW'(pos_rc);
    assign sum_rx = XW'(sum_rc);
    assign nrm_rx = XW'(req.corner_a);
    assign upd_x  = XW'(corner_k);

    assign sum_upd = '{missing: 1'b1,
                       sat: sum_rd_reg.sat || lane_sat[0] || lane_sat[1] || lane_sat[2],
                       sx: lane_sum_out[0], sy: lane_sum_out[1], sz: lane_sum_out[2]};

    always_comb
    begin
        sum_we = 1'b0;
        sum_wa = count_reg[AW-1:0];
        sum_wd = '{missing: !req.normal_finite || vng_short(in_nrm),
                   sat: 1'b0, sx: '0, sy: '0, sz: '0};
        if (do_load)
        begin
            sum_we = 1'b1;
        end
        else if (state_reg == S_TUPD && sum_rd_reg.missing)
        begin
            sum_we = 1'b1;
            sum_wa = upd_x[AW-1:0];
            sum_wd = sum_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            pos_mem[count_reg[AW-1:0]] <= in_pos;
            nrm_mem[count_reg[AW-1:0]] <= in_nrm;
        end
        pos_rd_reg <= pos_mem[pos_rx[AW-1:0]];
        nrm_rd_reg <= nrm_mem[nrm_rx[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_wa] <= sum_wd;
        end
        sum_rd_reg <= sum_mem[sum_rx[AW-1:0]];
    end

    assign lane_sum_in[0] = sum_rd_reg.sx;
    assign lane_sum_in[1] = sum_rd_reg.sy;
    assign lane_sum_in[2] = sum_rd_reg.sz;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        vng_lane #(
            .SUM_WIDTH (SUM_WIDTH)
        ) u_lane (
            .clk     (clk),
            .ctl     (lane_ctl),
            .mul_a   (e1_reg[J]),
            .mul_b   (e2_reg[K]),
            .mul_c   (e1_reg[K]),
            .mul_d   (e2_reg[J]),
            .sum_in  (lane_sum_in[i]),
            .len     (len),
            .sum_out (lane_sum_out[i]),
            .sum_sat (lane_sat[i]),
            .mag     (lane_mag[i]),
            .sq      (lane_sq[i]),
            .comp    (lane_comp[i])
        );
    end

    vng_merge #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_merge (
        .clk   (clk),
        .ctl   (merge_ctl),
        .mag_x (lane_mag[0]),
        .mag_y (lane_mag[1]),
        .mag_z (lane_mag[2]),
        .sq_x  (lane_sq[0]),
        .sq_y  (lane_sq[1]),
        .sq_z  (lane_sq[2]),
        .stat  (mstat),
        .len   (len)
    );

    always_comb
    begin
        state_next = state_reg;
        lane_ctl   = '0;
        merge_ctl  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.req_type == REQ_TRI && a_ok && b_ok && c_ok)
                begin
                    state_next = S_TA;
                end
                else if (accept && req.req_type == REQ_READ && a_ok)
                begin
                    state_next = S_RCHK;
                end
            end
            S_TA:   state_next = S_TB;
            S_TB:   state_next = S_TC;
            S_TC:   state_next = S_TMUL;
            S_TMUL: state_next = S_TSUB;
            S_TSUB: state_next = S_TRD;
            S_TRD:  state_next = S_TUPD;
            S_TUPD: state_next = (k_reg == 2'd2) ? S_IDLE : S_TRD;
            S_RCHK:
            begin
                if (sum_rd_reg.missing && !sum_rd_reg.sat)
                begin
                    lane_ctl.load = 1'b1;
                    state_next    = S_RSHIFT;
                end
                else
                begin
                    state_next = S_RFIN;
                end
            end
            S_RSHIFT:
            begin
                if (mstat.all_zero)
                begin
                    state_next = S_RFIN;
                end
                else if (mstat.any_big)
                begin
                    lane_ctl.shr = 1'b1;
                end
                else if (mstat.all_small)
                begin
                    lane_ctl.shl = 1'b1;
                end
                else
                begin
                    state_next = S_RSUM;
                end
            end
            S_RSUM:
            begin
                merge_ctl.sqrt_init = 1'b1;
                state_next          = S_RSQRT;
            end
            S_RSQRT:
            begin
                if (mstat.sqrt_done)
                begin
                    lane_ctl.div_init = 1'b1;
                    state_next        = S_RDIV;
                end
                else
                begin
                    merge_ctl.sqrt_step = 1'b1;
                end
            end
            S_RDIV:
            begin
                lane_ctl.div_step = 1'b1;
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = S_RFIN;
                end
            end
            S_RFIN:
            begin
                if (!pend_reg || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign req.ready = state_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && req.req_type == REQ_START)
            begin
                count_reg <= '0;
            end
            else if (do_load)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == S_TSUB)
            begin
                k_reg <= '0;
            end
            else if (state_reg == S_TUPD)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == S_RSQRT)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == S_RDIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (state_reg == S_RCHK)
            begin
                pend_reg <= 1'b1;
            end
            else if (state_reg == S_RFIN && out_free)
            begin
                pend_reg <= 1'b0;
            end
            if (state_reg == S_RFIN && pend_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ca_reg <= req.corner_a;
            cb_reg <= req.corner_b;
            cc_reg <= req.corner_c;
        end
        case (state_reg)
            S_TA:
            begin
                pa_reg <= pos_rd_reg;
            end
            S_TB:
            begin
                e1_reg[0] <= EDGE_W'(pos_rd_reg.x) - EDGE_W'(pa_reg.x);
                e1_reg[1] <= EDGE_W'(pos_rd_reg.y) - EDGE_W'(pa_reg.y);
                e1_reg[2] <= EDGE_W'(pos_rd_reg.z) - EDGE_W'(pa_reg.z);
            end
            S_TC:
            begin
                e2_reg[0] <= EDGE_W'(pos_rd_reg.x) - EDGE_W'(pa_reg.x);
                e2_reg[1] <= EDGE_W'(pos_rd_reg.y) - EDGE_W'(pa_reg.y);
                e2_reg[2] <= EDGE_W'(pos_rd_reg.z) - EDGE_W'(pa_reg.z);
            end
            S_RCHK:
            begin
                res_gen_reg <= 1'b0;
                if (vng_short(nrm_rd_reg))
                begin
                    res_reg <= '{x: '0, y: ONE_Q14, z: '0};
                end
                else
                begin
                    res_reg <= nrm_rd_reg;
                end
            end
            S_RSHIFT:
            begin
                res_gen_reg <= 1'b0;
                res_reg     <= '{x: '0, y: ONE_Q14, z: '0};
            end
            S_RDIV:
            begin
                res_gen_reg <= 1'b1;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
        if (state_reg == S_RFIN && pend_reg && out_free)
        begin
            out_reg     <= res_gen_reg ? gen_vec : res_reg;
            out_idx_reg <= ca_reg;
            out_gen_reg <= res_gen_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.out_normal_x  = out_reg.x;
    assign rsp.out_normal_y  = out_reg.y;
    assign rsp.out_normal_z  = out_reg.z;
    assign rsp.vertex_index  = out_idx_reg;
    assign rsp.was_generated = out_gen_reg;

endmodule
`default_nettype wire

@@ dv/vng_checker.sv @@
// Checker: watches both channels, predicts each read response and compares it.
`timescale 1ns / 100ps
module vng_checker
    import vng_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    vng_req_if        req,
    vng_rsp_if        rsp,
    output int        errors,
    output int        pending
);

    localparam int           NV      = DEF_MAX_VERTICES;
    localparam longint       SUM_HI  = (64'sd1 <<< (DEF_SUM_WIDTH - 1)) - 1;
    localparam longint       SUM_LO  = -SUM_HI - 1;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [9:0]         idx;
        logic               gen;
    } normal_rsp_t;

    normal_rsp_t normal_q[$];
    int          vcount;
    longint      vpos[NV][3];
    longint      vnrm[NV][3];
    bit          vmiss[NV];
    longint      vsum[NV][3];
    bit          vsat[NV];

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat_add(input longint s, input longint d, inout bit sat);
        longint r;
        r = s + d;
        if (r > SUM_HI)
        begin
            sat = 1;
            return SUM_HI;
        end
        if (r < SUM_LO)
        begin
            sat = 1;
            return SUM_LO;
        end
        return r;
    endfunction

    task automatic predict_request();
        longint          sq;
        longint          e1[3];
        longint          e2[3];
        longint          f[3];
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned len;
        longint unsigned q;
        int              rs;
        int              ls;
        int              k;
        int              ia;
        int              ib;
        int              ic;
        int              idx3[3];
        normal_rsp_t     r;
        ia = int'(req.corner_a);
        ib = int'(req.corner_b);
        ic = int'(req.corner_c);
        case (vng_req_e'(req.req_type))
            REQ_START: vcount = 0;
            REQ_LOAD:
            begin
                if (vcount < NV)
                begin
                    vpos[vcount][0] = longint'(req.pos_x);
                    vpos[vcount][1] = longint'(req.pos_y);
                    vpos[vcount][2] = longint'(req.pos_z);
                    vnrm[vcount][0] = longint'(req.in_normal_x);
                    vnrm[vcount][1] = longint'(req.in_normal_y);
                    vnrm[vcount][2] = longint'(req.in_normal_z);
                    sq = 0;
                    for (int i = 0; i < 3; i++) sq += vnrm[vcount][i] * vnrm[vcount][i];
                    vmiss[vcount] = !req.normal_finite || sq < 3;
                    for (int i = 0; i < 3; i++) vsum[vcount][i] = 0;
                    vsat[vcount] = 0;
                    vcount++;
                end
            end
            REQ_TRI:
            begin
                if (ia < vcount && ib < vcount && ic < vcount)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e1[i] = vpos[ib][i] - vpos[ia][i];
                        e2[i] = vpos[ic][i] - vpos[ia][i];
                    end
                    f[0] = e1[1] * e2[2] - e1[2] * e2[1];
                    f[1] = e1[2] * e2[0] - e1[0] * e2[2];
                    f[2] = e1[0] * e2[1] - e1[1] * e2[0];
                    idx3[0] = ia;
                    idx3[1] = ib;
                    idx3[2] = ic;
                    for (int j = 0; j < 3; j++)
                    begin
                        k = idx3[j];
                        if (vmiss[k])
                            for (int i = 0; i < 3; i++)
                                vsum[k][i] = sat_add(vsum[k][i], f[i], vsat[k]);
                    end
                end
            end
            default:
            begin
                if (ia < vcount)
                begin
                    r.idx = 10'(ia);
                    r.gen = 1'b0;
                    r.x = '0;
                    r.y = ONE_Q14;
                    r.z = '0;
                    if (vmiss[ia] && !vsat[ia])
                    begin
                        mx = 0;
                        for (int i = 0; i < 3; i++)
                        begin
                            m[i] = vsum[ia][i] < 0 ? -vsum[ia][i] : vsum[ia][i];
                            if (m[i] > mx) mx = m[i];
                        end
                        if (mx != 0)
                        begin
                            rs = 0;
                            ls = 0;
                            while ((mx >> rs) >= (64'd1 << 30)) rs++;
                            while ((mx << ls) < (64'd1 << 29)) ls++;
                            for (int i = 0; i < 3; i++) m[i] = (m[i] >> rs) << ls;
                            len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
                            for (int i = 0; i < 3; i++)
                            begin
                                q = (m[i] * 16384 + len / 2) / len;
                                f[i] = vsum[ia][i] < 0 ? -longint'(q) : longint'(q);
                            end
                            r.x = 16'(f[0]);
                            r.y = 16'(f[1]);
                            r.z = 16'(f[2]);
                            r.gen = 1'b1;
                        end
                    end
                    else
                    begin
                        sq = 0;
                        for (int i = 0; i < 3; i++) sq += vnrm[ia][i] * vnrm[ia][i];
                        if (sq >= 3)
                        begin
                            r.x = 16'(vnrm[ia][0]);
                            r.y = 16'(vnrm[ia][1]);
                            r.z = 16'(vnrm[ia][2]);
                        end
                    end
                    normal_q.push_back(r);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        normal_rsp_t e;
        if (!rst_n)
        begin
            vcount  = 0;
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (normal_q.size() == 0)
                begin
                    $display("%0t: response with none expected: idx %0d (%0d,%0d,%0d) gen %0b",
                             $time, rsp.vertex_index, rsp.out_normal_x, rsp.out_normal_y,
                             rsp.out_normal_z, rsp.was_generated);
                    errors++;
                end
                else
                begin
                    e = normal_q.pop_front();
                    if (rsp.out_normal_x !== e.x || rsp.out_normal_y !== e.y ||
                        rsp.out_normal_z !== e.z || rsp.vertex_index !== e.idx ||
                        rsp.was_generated !== e.gen)
                    begin
                        $display("%0t: mismatch expected idx %0d (%0d,%0d,%0d) gen %0b",
                                 $time, e.idx, e.x, e.y, e.z, e.gen);
                        $display("%0t:            actual   idx %0d (%0d,%0d,%0d) gen %0b",
                                 $time, rsp.vertex_index, rsp.out_normal_x,
                                 rsp.out_normal_y, rsp.out_normal_z, rsp.was_generated);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_request();
            pending = normal_q.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 100ps
module tb_top;
    import vng_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   sent;
    bit   no_gaps;
    bit   no_stall;

    vng_req_if req_ch();
    vng_rsp_if rsp_ch();

    vertex_normal_generator_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    vng_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    function automatic logic [9:0] rnd10();
        return 10'($urandom);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (no_stall)
            rsp_ch.ready <= 1'b1;
        else if ($urandom_range(0, 99) < 3)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) < 70);
    end

    task automatic send(input vng_req_e t, input logic [15:0] px, input logic [15:0] py,
                        input logic [15:0] pz, input logic [15:0] nx, input logic [15:0] ny,
                        input logic [15:0] nz, input logic fin, input logic [9:0] a,
                        input logic [9:0] b, input logic [9:0] c);
        int g;
        g = no_gaps ? 0 : gap_len();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= t;
        req_ch.pos_x         <= px;
        req_ch.pos_y         <= py;
        req_ch.pos_z         <= pz;
        req_ch.in_normal_x   <= nx;
        req_ch.in_normal_y   <= ny;
        req_ch.in_normal_z   <= nz;
        req_ch.normal_finite <= fin;
        req_ch.corner_a      <= a;
        req_ch.corner_b      <= b;
        req_ch.corner_c      <= c;
        do @(posedge clk); while (!req_ch.ready);
        sent++;
    endtask

    task automatic start_prim();
        send(REQ_START, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
             1'($urandom), rnd10(), rnd10(), rnd10());
    endtask

    task automatic load(input logic [15:0] px, input logic [15:0] py, input logic [15:0] pz,
                        input logic [15:0] nx, input logic [15:0] ny, input logic [15:0] nz,
                        input logic fin);
        send(REQ_LOAD, px, py, pz, nx, ny, nz, fin, rnd10(), rnd10(), rnd10());
    endtask

    task automatic tri_req(input logic [9:0] a, input logic [9:0] b, input logic [9:0] c);
        send(REQ_TRI, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
             1'($urandom), a, b, c);
    endtask

    task automatic read_req(input logic [9:0] a);
        send(REQ_READ, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
             1'($urandom), a, rnd10(), rnd10());
    endtask

    function automatic logic [15:0] pick_pos(input int mode);
        int p;
        if (mode == 0) return rnd16();
        if (mode == 1) return 16'(int'($urandom_range(0, 40)) - 20);
        p = $urandom_range(0, 2);
        return p == 0 ? 16'h8000 : (p == 1 ? 16'h7fff : 16'h0000);
    endfunction

    function automatic logic [15:0] pick_nrm(input bit tiny);
        if (tiny) return 16'(int'($urandom_range(0, 2)) - 1);
        return rnd16();
    endfunction

    task automatic random_prim();
        int  n;
        int  mode;
        int  ntri;
        int  p;
        bit  tiny;
        bit  heavy;
        logic [9:0] a;
        logic [9:0] b;
        logic [9:0] c;
        start_prim();
        heavy = ($urandom_range(0, 99) < 4);
        n = heavy ? 3 : $urandom_range(1, 10);
        mode = heavy ? 2 : $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
        begin
            tiny = ($urandom_range(0, 99) < 30);
            if (heavy)
                load(i == 1 ? 16'h7fff : 16'h8000, i == 2 ? 16'h7fff : 16'h8000, 16'h0000,
                     16'h0000, 16'h0000, 16'h0000, 1'b0);
            else
                load(pick_pos(mode), pick_pos(mode), pick_pos(mode), pick_nrm(tiny),
                     pick_nrm(tiny), pick_nrm(tiny), $urandom_range(0, 99) < 60);
        end
        ntri = heavy ? $urandom_range(120, 140) : $urandom_range(0, 12);
        for (int i = 0; i < ntri; i++)
        begin
            if (heavy)
                tri_req(10'd0, 10'd1, 10'd2);
            else
            begin
                a = 10'($urandom_range(0, n - 1));
                b = 10'($urandom_range(0, n - 1));
                c = 10'($urandom_range(0, n - 1));
                if ($urandom_range(0, 99) < 8) b = rnd10();
                tri_req(a, b, c);
            end
            if (heavy && i % 40 == 39) read_req(10'($urandom_range(0, 2)));
        end
        for (int i = 0; i < n + 1; i++)
        begin
            p = $urandom_range(0, 99);
            read_req(p < 90 ? 10'($urandom_range(0, n - 1)) : rnd10());
        end
        if ($urandom_range(0, 99) < 5)
            send(vng_req_e'($urandom_range(0, 3)), rnd16(), rnd16(), rnd16(), rnd16(),
                 rnd16(), rnd16(), 1'($urandom), rnd10(), rnd10(), rnd10());
    endtask

    initial
    begin
        int wait_cnt;
        rst_n                = 1'b0;
        sent                 = 0;
        no_gaps              = 0;
        no_stall             = 0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_START;
        req_ch.pos_x         = '0;
        req_ch.pos_y         = '0;
        req_ch.pos_z         = '0;
        req_ch.in_normal_x   = '0;
        req_ch.in_normal_y   = '0;
        req_ch.in_normal_z   = '0;
        req_ch.normal_finite = 1'b0;
        req_ch.corner_a      = '0;
        req_ch.corner_b      = '0;
        req_ch.corner_c      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_req(10'd0);
        tri_req(10'd0, 10'd0, 10'd0);
        load(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, 1'b1);
        load(16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h0000, 1'b1);
        load(16'h8000, 16'h7fff, 16'h7fff, 16'h0001, 16'h0001, 16'h0001, 1'b1);
        load(16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 1'b0);
        load(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        tri_req(10'd0, 10'd1, 10'd2);
        tri_req(10'd1, 10'd2, 10'd5);
        tri_req(10'd3, 10'd3, 10'd4);
        tri_req(10'd3, 10'd4, 10'd4);
        for (int i = 0; i < 6; i++) read_req(10'(i));
        start_prim();
        read_req(10'd0);
        load(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        read_req(10'd0);
        read_req(10'd1023);

        start_prim();
        for (int i = 0; i < 1025; i++)
            load(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                 1'($urandom_range(0, 1)));
        for (int i = 0; i < 20; i++)
        begin
            tri_req(rnd10(), rnd10(), rnd10());
            read_req(rnd10());
        end
        tri_req(10'd1023, 10'd1022, 10'd1021);
        read_req(10'd1023);

        while (sent < 2000)
        begin
            no_gaps  = ($urandom_range(0, 99) < 20);
            no_stall = ($urandom_range(0, 99) < 20);
            random_prim();
        end
        no_gaps = 0;
        req_ch.valid <= 1'b0;

        wait_cnt = 0;
        while (pending != 0)
        begin
            @(posedge clk);
            wait_cnt++;
            if (wait_cnt > 200000)
            begin
                $display("simulation failed");
                $finish;
            end
        end
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ vertex_normal_generator_top.f @@
rtl/vng_pkg.sv
rtl/vng_if.sv
rtl/vng_lane.sv
rtl/vng_merge.sv
rtl/vertex_normal_generator_top.sv
dv/vng_checker.sv
dv/tb_top.sv
